// File: src/pcd_pkg.sv
// Shared types, constants and helper functions for the pulldown cadence detector.
// No dependencies; every other file of the block imports this package.
package pcd_pkg;

  localparam int unsigned DiffW   = 20;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CountW  = 8;
  localparam int unsigned RunW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 20;

  localparam logic [ModeW-1:0]  FilmPhases        = 4'd5;
  localparam logic [RunW-1:0]   CadenceMismatches = 16'd4;
  localparam logic [ModeW-1:0]  VideoBob          = 4'd7;
  localparam logic [RunW-1:0]   RunMax            = 16'hFFFF;
  localparam logic [CountW-1:0] VerifyMax         = 8'hFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDiffThreshold     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMismatchThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCombThreshold     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFallbackEnable    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFallbackMode      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgVerifyCycles      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgVideoCycles       = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgRelockCycles      = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [DiffW-1:0]  DiffThresholdRst     = 20'd15;
  localparam logic [DiffW-1:0]  MismatchThresholdRst = 20'd900;
  localparam logic [DiffW-1:0]  CombThresholdRst     = 20'd150;
  localparam logic [ModeW-1:0]  FallbackModeRst      = 4'd8;
  localparam logic [CountW-1:0] VerifyCyclesRst      = 8'd4;
  localparam logic [CountW-1:0] VideoCyclesRst       = 8'd2;
  localparam logic [CountW-1:0] RelockCyclesRst      = 8'd12;

  // One input word as held in the input register.
  typedef struct packed {
    logic              cmd;
    logic [DiffW-1:0]  field_diff;
    logic [DiffW-1:0]  comb_factor;
    logic              is_odd;
    logic [PhaseW-1:0] frame_phase;
    logic              switch_limit_hit;
  } in_word_t;

  // One result word as held in the output register.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             flip;
    logic             fell_back;
  } out_word_t;

  // A complete film frame can be woven when the field sits at a non-zero
  // distance from the locked phase and its parity matches that distance.
  function automatic logic weave_ready(input logic [ModeW-1:0] mode,
                                       input logic odd,
                                       input logic [PhaseW-1:0] phase);
    logic [ModeW-1:0] ph;
    logic [ModeW-1:0] gap;
    begin
      ph = {1'b0, phase};
      if (mode >= FilmPhases || ph >= FilmPhases) begin
        weave_ready = 1'b0;
      end else begin
        if (ph >= mode) begin
          gap = ph - mode;
        end else begin
          gap = ph + FilmPhases - mode;
        end
        if (gap == '0) begin
          weave_ready = 1'b0;
        end else if (gap <= 4'd2) begin
          weave_ready = ~odd;
        end else begin
          weave_ready = odd;
        end
      end
    end
  endfunction

  // Film phase picked on lock: (phase + (odd ? 2 : 4)) mod 5, phase below 5.
  function automatic logic [ModeW-1:0] lock_phase(input logic odd,
                                                  input logic [PhaseW-1:0] phase);
    logic [ModeW-1:0] sum;
    begin
      sum = {1'b0, phase} + (odd ? 4'd2 : 4'd4);
      if (sum >= FilmPhases) begin
        lock_phase = sum - FilmPhases;
      end else begin
        lock_phase = sum;
      end
    end
  endfunction

endpackage

// File: src/pcd_in_if.sv
// Input channel of the pulldown cadence detector: valid/ready plus one field word.
// Depends on pcd_pkg for the field widths.
interface pcd_in_if import pcd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DiffW-1:0]  field_diff;
  logic [DiffW-1:0]  comb_factor;
  logic              is_odd;
  logic [PhaseW-1:0] frame_phase;
  logic              switch_limit_hit;

  modport source (output valid, cmd, field_diff, comb_factor, is_odd, frame_phase,
                  switch_limit_hit, input ready);
  modport sink   (input valid, cmd, field_diff, comb_factor, is_odd, frame_phase,
                  switch_limit_hit, output ready);
endinterface

// File: src/pcd_out_if.sv
// Result channel of the pulldown cadence detector: valid/ready plus one decision word.
// Depends on pcd_pkg for the field widths.
interface pcd_out_if import pcd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic             flip;
  logic             fell_back;

  modport source (output valid, mode, flip, fell_back, input ready);
  modport sink   (input valid, mode, flip, fell_back, output ready);
endinterface

// File: src/pulldown_cadence_detector_core.sv
// 3:2 pulldown cadence detector: one mode/weave decision per video field word.
// The field word passes the input register, then the result register; the
// decision logic and the state update sit between the two registers.
// Throughput: one word per cycle while the result side is not stalled. rst_ni
// clears the handshake state, the detector state (mode 7, counters zero) and
// loads the register defaults. Depends on pcd_pkg, pcd_in_if and pcd_out_if.
module pulldown_cadence_detector_core
  import pcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  pcd_in_if.sink             in_i,
  pcd_out_if.source          out_o
);

  // Configuration registers. The user must see that they are written only while the block is idle.
  logic [DiffW-1:0]  diff_thr_q, mism_thr_q, comb_thr_q;
  logic              fb_en_q;
  logic [ModeW-1:0]  fb_mode_q;
  logic [CountW-1:0] verify_cyc_q, video_cyc_q, relock_cyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_thr_q   <= DiffThresholdRst;
      mism_thr_q   <= MismatchThresholdRst;
      comb_thr_q   <= CombThresholdRst;
      fb_en_q      <= 1'b1;
      fb_mode_q    <= FallbackModeRst;
      verify_cyc_q <= VerifyCyclesRst;
      video_cyc_q  <= VideoCyclesRst;
      relock_cyc_q <= RelockCyclesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDiffThreshold:     diff_thr_q   <= cfg_data_i;
        CfgMismatchThreshold: mism_thr_q   <= cfg_data_i;
        CfgCombThreshold:     comb_thr_q   <= cfg_data_i;
        CfgFallbackEnable:    fb_en_q      <= cfg_data_i[0];
        CfgFallbackMode:      fb_mode_q    <= cfg_data_i[ModeW-1:0];
        CfgVerifyCycles:      verify_cyc_q <= cfg_data_i[CountW-1:0];
        CfgVideoCycles:       video_cyc_q  <= cfg_data_i[CountW-1:0];
        CfgRelockCycles:      relock_cyc_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The input register takes a new word whenever it is empty or
  // its word moves on into the result register this cycle, so a single result
  // waiting on the output side does not block the next word. Once a second
  // word sits in the input register behind a stalled result, the input side
  // stalls until the result is taken.
  logic      in_vld_q, out_vld_q;
  in_word_t  in_q;
  out_word_t out_q, res_d;
  logic      advance, in_take;

  assign advance   = !out_vld_q || out_o.ready;
  assign in_take   = in_i.valid && in_i.ready;
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.cmd              <= in_i.cmd;
      in_q.field_diff       <= in_i.field_diff;
      in_q.comb_factor      <= in_i.comb_factor;
      in_q.is_odd           <= in_i.is_odd;
      in_q.frame_phase      <= in_i.frame_phase;
      in_q.switch_limit_hit <= in_i.switch_limit_hit;
    end
    if (advance && in_vld_q) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.mode      = out_q.mode;
  assign out_o.flip      = out_q.flip;
  assign out_o.fell_back = out_q.fell_back;

  // Detector state. It is updated exactly when a word leaves the input
  // register, at the same edge that loads its result.
  logic [ModeW-1:0]  mode_now_q, mode_now_d, mode_before_q, mode_before_d;
  logic [RunW-1:0]   mism_run_q, mism_run_d;
  logic [CountW-1:0] verify_run_q, verify_run_d, temp_rep_q, temp_rep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_now_q    <= VideoBob;
      mode_before_q <= VideoBob;
      mism_run_q    <= '0;
      verify_run_q  <= '0;
      temp_rep_q    <= '0;
    end else if (advance && in_vld_q) begin
      mode_now_q    <= mode_now_d;
      mode_before_q <= mode_before_d;
      mism_run_q    <= mism_run_d;
      verify_run_q  <= verify_run_d;
      temp_rep_q    <= temp_rep_d;
    end
  end

  // A mismatch run longer than five times video_cycles marks a video source.
  logic [RunW-1:0] video_limit;
  assign video_limit = {{(RunW-CountW){1'b0}}, video_cyc_q}
                     + {{(RunW-CountW-2){1'b0}}, video_cyc_q, 2'b00};

  logic             artifact, to_video, verify_done, fell;
  logic [ModeW-1:0] lock_mode;

  always_comb begin
    mode_now_d    = mode_now_q;
    mode_before_d = mode_before_q;
    mism_run_d    = mism_run_q;
    verify_run_d  = verify_run_q;
    temp_rep_d    = temp_rep_q;
    fell          = 1'b0;
    artifact      = 1'b0;
    to_video      = 1'b0;
    verify_done   = 1'b0;
    lock_mode     = mode_now_q;
    res_d.mode      = mode_now_q;
    res_d.flip      = 1'b0;
    res_d.fell_back = 1'b0;

    if (in_q.cmd) begin
      // Restart clears the detection counters and reports the current mode.
      mism_run_d   = '0;
      verify_run_d = '0;
    end else begin
      if (in_q.field_diff > diff_thr_q) begin
        // Mismatching field. A strong difference while weaving a film phase
        // that would comb forces the fallback and arms a single relock cycle.
        to_video = mism_run_q > video_limit;
        artifact = (mode_now_q < FilmPhases) && fb_en_q && (mism_thr_q != '0)
                && (in_q.field_diff >= mism_thr_q)
                && weave_ready(mode_now_q, in_q.is_odd, in_q.frame_phase)
                && (in_q.comb_factor > comb_thr_q);
        if (artifact) begin
          to_video   = 1'b1;
          temp_rep_d = 8'd1;
        end
        if (to_video) begin
          mode_now_d   = fb_mode_q;
          verify_run_d = '0;
          fell         = 1'b1;
        end else if (mism_run_q != RunMax) begin
          mism_run_d = mism_run_q + 1'b1;
        end
      end else begin
        // Matching field. A match right after four mismatches closes one
        // cadence cycle; enough of those lock the film phase.
        if (mism_run_q == CadenceMismatches) begin
          verify_done = (temp_rep_q != '0) ? (verify_run_q >= temp_rep_q)
                                           : (verify_run_q >= verify_cyc_q);
          if (verify_done) begin
            temp_rep_d = '0;
            if ({1'b0, in_q.frame_phase} < FilmPhases) begin
              lock_mode = lock_phase(in_q.is_odd, in_q.frame_phase);
            end
            // A phase change while the tracker reports rapid switching
            // drops to the fallback mode and loads the relock count.
            if (mode_before_q != lock_mode && fb_en_q && in_q.switch_limit_hit) begin
              lock_mode    = fb_mode_q;
              verify_run_d = '0;
              temp_rep_d   = relock_cyc_q;
              fell         = 1'b1;
            end
            mode_now_d    = lock_mode;
            mode_before_d = lock_mode;
          end else if (verify_run_q != VerifyMax) begin
            verify_run_d = verify_run_q + 1'b1;
          end
        end else if (temp_rep_q != '0) begin
          verify_run_d = '0;
        end
        mism_run_d = '0;
      end
      res_d.mode      = mode_now_d;
      res_d.flip      = weave_ready(mode_now_d, in_q.is_odd, in_q.frame_phase);
      res_d.fell_back = fell;
    end
  end

endmodule

// File: src/pcd_checker.sv
// Port-level checker for pulldown_cadence_detector_core, attached by a bind.
// Depends on pcd_pkg for widths, register indexes and reset values.
module pcd_checker
  import pcd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i,
  input logic [CfgW-1:0]    cfg_data_i,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ModeW-1:0]   out_mode,
  input logic               out_flip,
  input logic               out_fell_back
);

  // Copy of the fallback mode register as seen on the configuration port.
  logic [ModeW-1:0] fb_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_mode_q <= FallbackModeRst;
    end else if (cfg_we_i && cfg_idx_i == CfgFallbackMode) begin
      fb_mode_q <= cfg_data_i[ModeW-1:0];
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_mode) && $stable(out_flip)
      && $stable(out_fell_back))
    else $error("result word changed while stalled");

  // Video modes never weave.
  a_video_no_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_mode >= FilmPhases |-> !out_flip)
    else $error("flip asserted in a video mode");

  // A forced fallback always reports the configured fallback mode.
  a_fallback_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_fell_back |-> out_mode == fb_mode_q)
    else $error("fallback reported with a wrong mode");

  // With no result pending the input side is never stalled.
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

endmodule

bind pulldown_cadence_detector_core pcd_checker u_pcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_mode     (out_o.mode),
  .out_flip     (out_o.flip),
  .out_fell_back(out_o.fell_back)
);

// File: sim/pulldown_cadence_detector_core_tb.sv
// Self-checking testbench for pulldown_cadence_detector_core: directed and random
// field words are driven through valid/ready channels and a cadence predictor checks
// each decision word. Depends on pcd_pkg, pcd_in_if, pcd_out_if and the core RTL.

import pcd_pkg::*;

// Holds a copy of the detector registers and state, predicts the decision word
// for every accepted field word and compares the words that come out in order.
class cadence_scoreboard;
  logic [DiffW-1:0]  diff_thr;
  logic [DiffW-1:0]  mism_thr;
  logic [DiffW-1:0]  comb_thr;
  logic              fb_en;
  logic [ModeW-1:0]  fb_mode;
  logic [CountW-1:0] verify_n;
  logic [CountW-1:0] video_n;
  logic [CountW-1:0] relock_n;

  logic [ModeW-1:0]  mode_now;
  logic [ModeW-1:0]  mode_prev;
  logic [RunW-1:0]   mism_run;
  logic [CountW-1:0] verify_run;
  logic [CountW-1:0] temp_repeat;

  out_word_t   decisions[$];
  int unsigned errors;

  function new();
    diff_thr    = DiffThresholdRst;
    mism_thr    = MismatchThresholdRst;
    comb_thr    = CombThresholdRst;
    fb_en       = 1'b1;
    fb_mode     = FallbackModeRst;
    verify_n    = VerifyCyclesRst;
    video_n     = VideoCyclesRst;
    relock_n    = RelockCyclesRst;
    mode_now    = VideoBob;
    mode_prev   = VideoBob;
    mism_run    = '0;
    verify_run  = '0;
    temp_repeat = '0;
    errors      = 0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      CfgDiffThreshold:     diff_thr = data;
      CfgMismatchThreshold: mism_thr = data;
      CfgCombThreshold:     comb_thr = data;
      CfgFallbackEnable:    fb_en    = data[0];
      CfgFallbackMode:      fb_mode  = data[ModeW-1:0];
      CfgVerifyCycles:      verify_n = data[CountW-1:0];
      CfgVideoCycles:       video_n  = data[CountW-1:0];
      CfgRelockCycles:      relock_n = data[CountW-1:0];
      default: ;
    endcase
  endfunction

  // A film frame is complete when the field is off the locked phase and its
  // parity fits the distance to it; video modes never weave.
  function logic frame_complete(logic [ModeW-1:0] m, logic odd, logic [PhaseW-1:0] ph);
    int gap;
    if (m >= FilmPhases || ph >= FilmPhases) return 1'b0;
    gap = (int'(ph) + int'(FilmPhases) - int'(m)) % int'(FilmPhases);
    if (gap == 0) return 1'b0;
    return (gap <= 2) ? ~odd : odd;
  endfunction

  function int pending();
    return decisions.size();
  endfunction

  function void note_word(in_word_t w);
    out_word_t r;
    logic      to_video;
    logic      lock_due;
    r = '0;
    if (w.cmd) begin
      mism_run   = '0;
      verify_run = '0;
      r.mode     = mode_now;
    end else begin
      if (w.field_diff > diff_thr) begin
        // A run longer than five times the video count means a video source.
        to_video = (32'(mism_run) > 32'(video_n) * 5);
        if (mode_now < FilmPhases && fb_en && mism_thr != '0 &&
            w.field_diff >= mism_thr && w.comb_factor > comb_thr &&
            frame_complete(mode_now, w.is_odd, w.frame_phase)) begin
          to_video    = 1'b1;
          temp_repeat = 8'd1;
        end
        if (to_video) begin
          mode_now    = fb_mode;
          verify_run  = '0;
          r.fell_back = 1'b1;
        end else if (mism_run != RunMax) begin
          mism_run++;
        end
      end else begin
        if (mism_run == CadenceMismatches) begin
          lock_due = (temp_repeat != '0) ? (verify_run >= temp_repeat)
                                         : (verify_run >= verify_n);
          if (lock_due) begin
            temp_repeat = '0;
            if (w.frame_phase < FilmPhases) begin
              mode_now = ModeW'((int'(w.frame_phase) + (w.is_odd ? 2 : 4))
                                % int'(FilmPhases));
            end
            if (mode_prev != mode_now && fb_en && w.switch_limit_hit) begin
              mode_now    = fb_mode;
              verify_run  = '0;
              temp_repeat = relock_n;
              r.fell_back = 1'b1;
            end
            mode_prev = mode_now;
          end else if (verify_run != VerifyMax) begin
            verify_run++;
          end
        end else if (temp_repeat != '0) begin
          verify_run = '0;
        end
        mism_run = '0;
      end
      r.mode = mode_now;
      r.flip = frame_complete(mode_now, w.is_odd, w.frame_phase);
    end
    decisions.push_back(r);
  endfunction

  function void check_word(out_word_t got);
    out_word_t want;
    if (decisions.size() == 0) begin
      $display("%0t: decision word with none pending: mode %0d flip %0b fell_back %0b",
               $time, got.mode, got.flip, got.fell_back);
      errors++;
    end else begin
      want = decisions.pop_front();
      if (got.mode !== want.mode) begin
        $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
        errors++;
      end
      if (got.flip !== want.flip) begin
        $display("%0t: flip expected %0b actual %0b", $time, want.flip, got.flip);
        errors++;
      end
      if (got.fell_back !== want.fell_back) begin
        $display("%0t: fell_back expected %0b actual %0b", $time, want.fell_back,
                 got.fell_back);
        errors++;
      end
    end
  endfunction
endclass

module pulldown_cadence_detector_core_tb;

  localparam int unsigned DiffMax = (1 << DiffW) - 1;

  // Register set for one phase of the run, ordered by register index.
  typedef logic [CfgW-1:0] reg_set_t [8];

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  pcd_in_if  in_if ();
  pcd_out_if out_if ();

  pulldown_cadence_detector_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  cadence_scoreboard sb;

  // Percentages of cycles in which the sender holds back a word and the
  // receiver refuses one. They change from phase to phase.
  int unsigned src_idle = 0;
  int unsigned snk_idle = 0;

  // Generator state: position inside the five-field cadence (position zero is
  // the repeated field, the others differ), the running frame counter, the
  // field parity and whether the current cadence group is clean.
  int   cad_pos     = 0;
  int   phase_ctr   = 0;
  logic parity      = 1'b0;
  logic group_clean = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog for the whole run, set with a large margin above its expected
  // length.
  initial begin
    #4000000;
    $display("FAIL pulldown_cadence_detector_core");
    $finish;
  end

  // Result side: check each accepted decision word, then choose whether the
  // receiver takes a word at the next edge.
  initial begin : result_sink
    out_word_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.mode      = out_if.mode;
        got.flip      = out_if.flip;
        got.fell_back = out_if.fell_back;
        sb.check_word(got);
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  function automatic in_word_t make_word(logic cmd, int unsigned diff, int unsigned comb,
                                         logic odd, int unsigned phase, logic limit);
    in_word_t w;
    w.cmd              = cmd;
    w.field_diff       = DiffW'(diff);
    w.comb_factor      = DiffW'(comb);
    w.is_odd           = odd;
    w.frame_phase      = PhaseW'(phase);
    w.switch_limit_hit = limit;
    return w;
  endfunction

  // Offers one word, with random idle cycles ahead of it, and holds it until
  // the block takes it. Valid stays high afterwards so that back-to-back words
  // need no extra edge; whoever runs next decides its level.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.cmd              <= w.cmd;
    in_if.field_diff       <= w.field_diff;
    in_if.comb_factor      <= w.comb_factor;
    in_if.is_odd           <= w.is_odd;
    in_if.frame_phase      <= w.frame_phase;
    in_if.switch_limit_hit <= w.switch_limit_hit;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(w);
  endtask

  // Four differing fields in a row, the body of one cadence cycle.
  task automatic send_mismatch_run(input int unsigned diff, input int unsigned phase0);
    for (int k = 0; k < 4; k++) begin
      send_word(make_word(1'b0, diff, k * 40, k[0], (phase0 + k) % 8, k[1]));
    end
  endtask

  // Stops the sender and waits until every pending decision has come out,
  // then lets the two-stage pipeline settle.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all eight registers on consecutive edges; the block is idle here.
  task automatic apply_config(input reg_set_t r);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= r[i];
      @(posedge clk_i);
      sb.set_reg(CfgIdxW'(i), r[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Register sets per phase. Order: diff, mismatch and comb thresholds,
  // fallback enable, fallback mode, verify, video and relock cycles.
  function automatic reg_set_t phase_regs(int p);
    reg_set_t r;
    case (p)
      0: r = '{15, 900, 150, 1, 8, 1, 2, 12};
      1: r = '{15, 900, 150, 1, 8, 4, 2, 12};
      // Lowest settings: any nonzero difference mismatches and a second
      // mismatch already falls back.
      2: r = '{0, 1, 0, 1, 15, 0, 0, 0};
      // Highest settings: no field can mismatch and no lock is ever due.
      3: r = '{DiffMax, DiffMax, DiffMax, 0, 5, 255, 255, 255};
      // Fallback code that is itself a film phase.
      4: r = '{40, 500, 200, 1, 2, 2, 3, 3};
      // Artifact check switched off by a zero mismatch threshold.
      5: r = '{15, 0, 150, 1, 9, 1, 1, 1};
      6: r = '{1000, 2000, 50000, 1, 6, 3, 5, 200};
      7: r = '{15, 900, 150, 1, 8, 0, 2, 0};
      default: begin
        r[0] = CfgW'($urandom_range(200, 0));
        r[1] = CfgW'($urandom_range(3000, 0));
        r[2] = CfgW'($urandom_range(DiffMax, 0));
        r[3] = CfgW'($urandom_range(1));
        r[4] = CfgW'($urandom_range(15, 0));
        r[5] = CfgW'($urandom_range(6, 0));
        r[6] = CfgW'($urandom_range(10, 0));
        r[7] = CfgW'($urandom_range(8, 0));
      end
    endcase
    return r;
  endfunction

  // Builds the next random field. Most cadence groups are clean 3:2 runs with
  // random values on the right side of the thresholds, so that locks, artifact
  // fallbacks and rapid-switch fallbacks all happen; the rest is noise.
  task automatic gen_word(output in_word_t w);
    int unsigned thr;
    int unsigned lo;
    if (cad_pos == 0) begin
      group_clean = ($urandom_range(99) < 85);
      // Shift the frame counter now and then so the locked phase changes.
      if ($urandom_range(4) == 0) begin
        phase_ctr = $urandom_range(4, 0);
        parity    = 1'($urandom_range(1));
      end
    end
    thr = 32'(sb.diff_thr);
    if (!group_clean) begin
      w = make_word($urandom_range(24) == 0, $urandom, $urandom, 1'($urandom_range(1)),
                    $urandom_range(7, 0), 1'($urandom_range(1)));
    end else begin
      w = make_word(1'b0, 0, 0, parity, phase_ctr, $urandom_range(99) < 30);
      if ($urandom_range(99) < 3) w.frame_phase = PhaseW'($urandom_range(7, 5));
      if (cad_pos == 0 || thr == DiffMax) begin
        w.field_diff = DiffW'($urandom_range(thr, 0));
      end else begin
        lo = thr + 1;
        if ($urandom_range(4) == 0 && sb.mism_thr > lo) lo = 32'(sb.mism_thr);
        w.field_diff = DiffW'($urandom_range(DiffMax, lo));
      end
      if ($urandom_range(1) == 0 || sb.comb_thr == DiffMax) begin
        w.comb_factor = DiffW'($urandom_range(32'(sb.comb_thr), 0));
      end else begin
        w.comb_factor = DiffW'($urandom_range(DiffMax, 32'(sb.comb_thr) + 1));
      end
      if ($urandom_range(99) == 0) w.cmd = 1'b1;
    end
    cad_pos   = (cad_pos + 1) % 5;
    phase_ctr = (phase_ctr + 1) % 5;
    parity    = ~parity;
  endtask

  initial begin : stimulus
    in_word_t w;
    int       n_items;
    sb = new();
    in_if.valid            <= 1'b0;
    in_if.cmd              <= 1'b0;
    in_if.field_diff       <= '0;
    in_if.comb_factor      <= '0;
    in_if.is_odd           <= 1'b0;
    in_if.frame_phase      <= '0;
    in_if.switch_limit_hit <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= CfgDiffThreshold;
    cfg_data_i             <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the default thresholds with a verify count of one, so
    // that a lock comes after two cadence cycles.
    apply_config(phase_regs(0));
    src_idle = 36;
    snk_idle = 36;
    send_word(make_word(1'b1, 0, 0, 1'b0, 0, 1'b0));           // restart from reset
    send_word(make_word(1'b0, 0, 0, 1'b0, 0, 1'b0));           // repeated field
    send_word(make_word(1'b0, DiffMax, 0, 1'b1, 1, 1'b0));     // largest difference
    send_word(make_word(1'b0, 100, DiffMax, 1'b0, 2, 1'b1));   // largest comb
    send_word(make_word(1'b0, 16, 5, 1'b1, 3, 1'b0));          // just above threshold
    send_word(make_word(1'b0, 16, 5, 1'b0, 4, 1'b0));
    send_word(make_word(1'b0, 15, 5, 1'b1, 5, 1'b0));          // at threshold: first cycle
    send_mismatch_run(200, 6);
    // Second confirmed cycle locks the film phase.
    send_word(make_word(1'b0, 0, 0, 1'b1, 2, 1'b0));
    // Weave artifact on a field that would flip: forced back to video.
    send_word(make_word(1'b0, DiffMax, DiffMax, 1'b0, 0, 1'b0));
    send_word(make_word(1'b0, DiffMax, 0, 1'b1, 7, 1'b1));
    send_word(make_word(1'b1, DiffMax, DiffMax, 1'b1, 7, 1'b1)); // restart, all ones
    send_mismatch_run(300, 0);
    send_word(make_word(1'b0, 0, 0, 1'b0, 4, 1'b0));
    send_mismatch_run(DiffMax, 2);
    // Lock onto a new phase while the switch tracker is full: rapid-switch
    // fallback with the relock count loaded.
    send_word(make_word(1'b0, 3, 0, 1'b1, 1, 1'b1));
    drain_results();

    // Random phases, each with its own register set and one of four idle patterns. Every
    // phase starts only after all decisions of the one before have arrived.
    for (int p = 1; p <= 8; p++) begin
      apply_config(phase_regs(p));
      case (p % 4)
        0: begin src_idle = 0;  snk_idle = 0;  end
        1: begin src_idle = 0;  snk_idle = 0;  end
        2: begin src_idle = 47; snk_idle = 0;  end
        default: begin src_idle = 0; snk_idle = 47; end
      endcase
      if (p == 4 || p == 8) begin
        src_idle = 36;
        snk_idle = 36;
      end
      n_items = (p == 3) ? 100 : 230;
      for (int k = 0; k < n_items; k++) begin
        gen_word(w);
        send_word(w);
      end
      drain_results();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS pulldown_cadence_detector_core");
    end else begin
      $display("FAIL pulldown_cadence_detector_core");
    end
    $finish;
  end

endmodule

// File: sim.f
src/pcd_pkg.sv
src/pcd_in_if.sv
src/pcd_out_if.sv
src/pulldown_cadence_detector_core.sv
src/pcd_checker.sv
sim/pulldown_cadence_detector_core_tb.sv
